@@ hw/rtl/skcg_pkg.sv @@
// Shared types and constants for the soft-knee compressor gain block.
// Holds the register map, the configuration word and the multiplier
// request/response bundles. Depends on nothing.
`timescale 1ns / 1ps

package skcg_pkg;

    // Register map of the configuration write channel
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_SLOPE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF = 3'd5;

    // Register values after reset
    localparam logic [15:0] RST_THRESHOLD    = 16'hEC00;  // -20 dB
    localparam logic [14:0] RST_KNEE_WIDTH   = 15'd1536;  // 6 dB
    localparam logic [15:0] RST_RATIO_SLOPE  = 16'hA000;  // -0.75
    localparam logic [15:0] RST_KNEE_SCALE   = 16'd5461;
    localparam logic [15:0] RST_ATTACK_COEF  = 16'd64881;
    localparam logic [15:0] RST_RELEASE_COEF = 16'd65470;

    // Serial multiplier geometry: wide multiplicand, radix-4 multiplier digits
    localparam int unsigned MUL_MW    = 48;
    localparam int unsigned MUL_BW    = 16;
    localparam int unsigned MUL_DIG   = 2;
    localparam int unsigned MUL_STEPS = MUL_BW / MUL_DIG;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);

    typedef struct packed {
        logic [15:0] threshold;     // signed Q8.8
        logic [14:0] knee_width;    // unsigned Q7.8
        logic [15:0] ratio_slope;   // signed Q1.15
        logic [15:0] knee_scale;    // unsigned Q0.16
        logic [15:0] attack_coef;   // unsigned Q0.16
        logic [15:0] release_coef;  // unsigned Q0.16
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [MUL_MW-1:0] mcand;
        logic [MUL_BW-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [MUL_MW+MUL_BW-1:0] prod;
    } mul_rsp_t;

endpackage

@@ hw/rtl/skcg_cfg.sv @@
// Configuration register file of the soft-knee compressor gain block.
// Decodes register writes into one configuration word; uses skcg_pkg.
`timescale 1ns / 1ps

module skcg_cfg
    import skcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [15:0]          wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything as it is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_THRESHOLD:    cfg_next.threshold    = wr_data;
                REG_KNEE_WIDTH:   cfg_next.knee_width   = wr_data[14:0];
                REG_RATIO_SLOPE:  cfg_next.ratio_slope  = wr_data;
                REG_KNEE_SCALE:   cfg_next.knee_scale   = wr_data;
                REG_ATTACK_COEF:  cfg_next.attack_coef  = wr_data;
                REG_RELEASE_COEF: cfg_next.release_coef = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= RST_THRESHOLD;
            cfg_reg.knee_width   <= RST_KNEE_WIDTH;
            cfg_reg.ratio_slope  <= RST_RATIO_SLOPE;
            cfg_reg.knee_scale   <= RST_KNEE_SCALE;
            cfg_reg.attack_coef  <= RST_ATTACK_COEF;
            cfg_reg.release_coef <= RST_RELEASE_COEF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/skcg_mul.sv @@
// Serial-parallel unsigned multiplier, two multiplier bits per cycle.
// The multiplier shifts out of the low product register as the product
// shifts in. Uses skcg_pkg for its geometry and request/response types.
`timescale 1ns / 1ps

module skcg_mul
    import skcg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [MUL_MW-1:0]    mcand_reg;
    logic [MUL_MW-1:0]    hi_reg;
    logic [MUL_BW-1:0]    lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_MW+1:0]    sum;

    // Add the current digit times the multiplicand to the high part
    always_comb
    begin
        sum = {2'b00, hi_reg}
            + (lo_reg[0] ? {2'b00, mcand_reg} : '0)
            + (lo_reg[1] ? {1'b0, mcand_reg, 1'b0} : '0);
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Load operands, then shift the product right one digit per step
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg <= req.mcand;
            hi_reg    <= '0;
            lo_reg    <= req.mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_MW+1:MUL_DIG];
            lo_reg <= {sum[MUL_DIG-1:0], lo_reg[MUL_BW-1:MUL_DIG]};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg, lo_reg};

    // A new product may not be started over one in progress
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    // Completion only ever follows the final step
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && $past(cnt_reg) == MUL_LAST))
        else $error("multiplier done without finishing its steps");

endmodule

@@ hw/rtl/soft_knee_compressor_gain.sv @@
// Top level of the soft-knee compressor gain computer with peak detector.
// Sequencer, output word register; instantiates skcg_cfg and skcg_mul.
// Uses skcg_pkg for types, register map and multiplier geometry.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata[15:0] level_db
//  m_       | out       | m_tvalid/m_tready  | m_tdata curve_db, smoothed_red_db
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One word is worked at a time; the radix-4 serial multiplier sets the pace.
// A word below the knee needs no curve product, one above it needs one and one
// inside it three chained products; every word then takes one detector product.
// Reset clears the detector history and loads the default registers.
// A stalled output holds the finished word; the next input is taken meanwhile,
// and only the final hand-over waits for the output register to free up.
`timescale 1ns / 1ps

module soft_knee_compressor_gain
    import skcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [15:0] level_db
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,    // [15:0] curve_db, [31:16] smoothed_reduction_db
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CLASS = 12'b0000_0000_0010,
        ST_KSQ   = 12'b0000_0000_0100,
        ST_KSC   = 12'b0000_0000_1000,
        ST_KSL   = 12'b0000_0001_0000,
        ST_ABV   = 12'b0000_0010_0000,
        ST_TERM  = 12'b0000_0100_0000,
        ST_RED   = 12'b0000_1000_0000,
        ST_DIFF  = 12'b0001_0000_0000,
        ST_DET   = 12'b0010_0000_0000,
        ST_ROUND = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } state_t;

    function automatic logic [15:0] sat16(input logic signed [34:0] v);
        logic [15:0] res;
        if (v > 35'sd32767)
            res = 16'h7FFF;
        else if (v < -35'sd32768)
            res = 16'h8000;
        else
            res = v[15:0];
        return res;
    endfunction

    cfg_t     cfg;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    state_t       state_reg, state_next;
    logic [15:0]  x_reg;
    logic [16:0]  d_reg;
    logic         knee_reg;
    logic         tneg_reg;
    logic [24:0]  term_reg;
    logic [15:0]  curve_reg;
    logic [15:0]  r_reg;
    logic         dneg_reg;
    logic [34:0]  v_reg;
    logic [15:0]  prev_reg, prev_next;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;

    logic               in_acc;
    logic               out_load;
    logic [16:0]        d_in;
    logic signed [17:0] twod;
    logic signed [17:0] wpos;
    logic               below_knee;
    logic               above_knee;
    logic [17:0]        s_sum;
    logic [16:0]        d_abs;
    logic [16:0]        slope_ext;
    logic [16:0]        slope_abs;
    logic [23:0]        tmag;
    logic [24:0]        term_val;
    logic [25:0]        yg;
    logic [25:0]        neg_term;
    logic [16:0]        diff;
    logic [16:0]        diff_abs;
    logic [15:0]        coef_sel;
    logic [34:0]        prod_ext;
    logic [34:0]        r_shift;
    logic [34:0]        v_val;
    logic signed [34:0] v_rnd;
    logic signed [34:0] v_shr;

    skcg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    skcg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Region tests and operand preparation
    always_comb
    begin
        d_in       = {s_tdata[15], s_tdata} - {cfg.threshold[15], cfg.threshold};
        twod       = $signed({d_reg, 1'b0});
        wpos       = $signed({3'b000, cfg.knee_width});
        below_knee = (twod < -wpos);
        above_knee = (twod > wpos);
        s_sum      = 18'(twod + wpos);
        d_abs      = d_reg[16] ? (17'd0 - d_reg) : d_reg;
        slope_ext  = {cfg.ratio_slope[15], cfg.ratio_slope};
        slope_abs  = cfg.ratio_slope[15] ? (17'd0 - slope_ext) : slope_ext;
    end

    // Round the product to the curve term, ties away from zero
    always_comb
    begin
        if (knee_reg)
            tmag = {1'b0, mul_rsp.prod[63:41]} + {23'd0, mul_rsp.prod[40]};
        else
            tmag = {1'b0, mul_rsp.prod[37:15]} + {23'd0, mul_rsp.prod[14]};
        term_val = tneg_reg ? (25'd0 - {1'b0, tmag}) : {1'b0, tmag};
    end

    // Curve output, reduction and detector arithmetic
    always_comb
    begin
        yg       = {{10{x_reg[15]}}, x_reg} + {term_reg[24], term_reg};
        neg_term = 26'd0 - {term_reg[24], term_reg};
        diff     = {prev_reg[15], prev_reg} - {r_reg[15], r_reg};
        diff_abs = diff[16] ? (17'd0 - diff) : diff;
        coef_sel = ($signed(r_reg) > $signed(prev_reg)) ? cfg.attack_coef
                                                        : cfg.release_coef;
        prod_ext = {3'b000, mul_rsp.prod[31:0]};
        r_shift  = {{3{r_reg[15]}}, r_reg, 16'd0};
        v_val    = dneg_reg ? (r_shift - prod_ext) : (r_shift + prod_ext);
        v_rnd    = $signed(v_reg) + (v_reg[34] ? 35'sd32767 : 35'sd32768);
        v_shr    = v_rnd >>> 16;
        prev_next = sat16(v_shr);
    end

    // Sequencer and multiplier requests
    always_comb
    begin
        state_next     = state_reg;
        mul_req.start  = 1'b0;
        mul_req.mcand  = '0;
        mul_req.mplier = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                priority if (below_knee)
                begin
                    state_next = ST_RED;
                end
                else if (above_knee)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = {32'd0, d_abs[15:0]};
                    mul_req.mplier = slope_abs[15:0];
                    state_next     = ST_ABV;
                end
                else
                begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = {32'd0, s_sum[15:0]};
                    mul_req.mplier = s_sum[15:0];
                    state_next     = ST_KSQ;
                end
            end
            ST_KSQ:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = {16'd0, mul_rsp.prod[31:0]};
                    mul_req.mplier = cfg.knee_scale;
                    state_next     = ST_KSC;
                end
            end
            ST_KSC:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = mul_rsp.prod[47:0];
                    mul_req.mplier = slope_abs[15:0];
                    state_next     = ST_KSL;
                end
            end
            ST_KSL, ST_ABV:
            begin
                if (mul_rsp.done)
                    state_next = ST_TERM;
            end
            ST_TERM:  state_next = ST_RED;
            ST_RED:   state_next = ST_DIFF;
            ST_DIFF:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = {32'd0, diff_abs[15:0]};
                mul_req.mplier = coef_sel;
                state_next     = ST_DET;
            end
            ST_DET:
            begin
                if (mul_rsp.done)
                    state_next = ST_ROUND;
            end
            ST_ROUND: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state and detector history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_ROUND)
                prev_reg <= prev_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the current word
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= s_tdata;
            d_reg <= d_in;
        end
        if (state_reg == ST_CLASS)
        begin
            knee_reg <= !above_knee;
            tneg_reg <= above_knee ? (cfg.ratio_slope[15] ^ d_reg[16])
                                   : cfg.ratio_slope[15];
            if (below_knee)
                term_reg <= '0;
        end
        if (state_reg == ST_TERM)
            term_reg <= term_val;
        if (state_reg == ST_RED)
        begin
            curve_reg <= sat16(35'($signed(yg)));
            r_reg     <= sat16(35'($signed(neg_term)));
        end
        if (state_reg == ST_DIFF)
            dneg_reg <= diff[16];
        if (state_reg == ST_DET && mul_rsp.done)
            v_reg <= v_val;
        if (out_load)
            out_data_reg <= {prev_reg, curve_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Detector history moves only when a result is rounded
    a_prev_only_round: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(prev_reg) |-> $past(state_reg == ST_ROUND))
        else $error("detector history changed outside rounding");

    // Every multiply wait state has a product in progress or just finished
    a_mul_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KSQ || state_reg == ST_KSC || state_reg == ST_KSL ||
         state_reg == ST_ABV || state_reg == ST_DET) |-> (mul_rsp.busy || mul_rsp.done))
        else $error("waiting on a multiplier that was never started");

    // A new output word appears only from the hand-over state
    a_out_from_handover: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("output word raised outside hand-over");

endmodule

@@ dv/soft_knee_compressor_gain_tb.sv @@
// Self-checking bench for soft_knee_compressor_gain: predicts curve level and smoothed
// reduction per level word, checks every output word, and walks several register settings.
// Depends on skcg_pkg and the soft_knee_compressor_gain RTL.
`timescale 1ns / 1ps

module soft_knee_compressor_gain_tb;
    import skcg_pkg::*;

    localparam int unsigned ITEMS_PER_SETTING = 145;
    localparam int unsigned DRAIN_CYCLES      = 60;
    localparam int unsigned LONG_HOLD_CYCLES  = 300;
    localparam longint      TIMEOUT_NS        = 5_000_000;

    // Indexes outside the register map; writes to them must leave every register alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [15:0] curve;
        logic [15:0] reduction;
    } gain_word_t;

    // Gain predictor and expected-word store
    class gain_checker;
        longint thr;
        longint kw;
        longint slope;
        longint kscale;
        longint attack;
        longint release_c;
        longint held_reduction;
        gain_word_t pending_gain[$];
        int unsigned fails;

        function new();
            thr            = longint'($signed(RST_THRESHOLD));
            kw             = longint'(RST_KNEE_WIDTH);
            slope          = longint'($signed(RST_RATIO_SLOPE));
            kscale         = longint'(RST_KNEE_SCALE);
            attack         = longint'(RST_ATTACK_COEF);
            release_c      = longint'(RST_RELEASE_COEF);
            held_reduction = 0;
            fails          = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                REG_THRESHOLD:    thr = longint'($signed(data));
                REG_KNEE_WIDTH:   kw = longint'(data[14:0]);
                REG_RATIO_SLOPE:  slope = longint'($signed(data));
                REG_KNEE_SCALE:   kscale = longint'(data);
                REG_ATTACK_COEF:  attack = longint'(data);
                REG_RELEASE_COEF: release_c = longint'(data);
                default:          ;
            endcase
        endfunction

        // Round to nearest, ties away from zero
        function longint round_shift(longint v, int sh);
            longint mag;
            mag = (v < 0) ? -v : v;
            mag = (mag + (longint'(1) << (sh - 1))) >> sh;
            return (v < 0) ? -mag : mag;
        endfunction

        function longint clip16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // Work out the curve level and detector output for one accepted level word
        function void note_level(logic [15:0] level);
            longint x;
            longint d;
            longint yg;
            longint s;
            longint slope_mag;
            longint term;
            longint red;
            longint coef;
            longint y;
            gain_word_t w;
            x = longint'($signed(level));
            d = x - thr;
            if (2 * d < -kw)
            begin
                yg = x;
            end
            else if (2 * d <= kw && -2 * d <= kw)
            begin
                // quadratic knee term, positions counted in half Q8.8 steps
                s = 2 * d + kw;
                slope_mag = (slope < 0) ? -slope : slope;
                term = round_shift(s * s * kscale * slope_mag, 41);
                yg = x + ((slope < 0) ? -term : term);
            end
            else
            begin
                yg = x + round_shift(slope * d, 15);
            end
            red  = clip16(x - yg);
            coef = (red > held_reduction) ? attack : release_c;
            y = clip16(round_shift(coef * held_reduction + (65536 - coef) * red, 16));
            held_reduction = y;
            w.curve     = 16'(clip16(yg));
            w.reduction = 16'(y);
            pending_gain.push_back(w);
        endfunction

        // Compare one output word with the oldest expectation
        function void check_word(logic [31:0] data);
            gain_word_t w;
            if (pending_gain.size() == 0)
            begin
                $display("%0t: unexpected output word %h", $time, data);
                fails++;
                return;
            end
            w = pending_gain.pop_front();
            if (data[15:0] !== w.curve)
            begin
                $display("%0t: curve_db expected %h actual %h", $time, w.curve, data[15:0]);
                fails++;
            end
            if (data[31:16] !== w.reduction)
            begin
                $display("%0t: smoothed_reduction_db expected %h actual %h",
                         $time, w.reduction, data[31:16]);
                fails++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;    // [15:0] level_db
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;         // [15:0] curve_db, [31:16] smoothed_reduction_db
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
    logic [15:0]          cfg_data = '0;

    gain_checker gain_sb = new();
    int unsigned words_seen = 0;
    bit          send_steady = 1'b0;
    bit          take_steady = 1'b0;

    soft_knee_compressor_gain dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one level word after a random gap; return at the falling edge after acceptance
    task automatic send_level(logic [15:0] level);
        int unsigned gap;
        if ($urandom_range(0, 29) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= level;
        do
            @(posedge clk);
        while (!s_tready);
        gain_sb.note_level(level);
        @(negedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        gain_sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic apply_settings(logic [15:0] t, logic [15:0] w, logic [15:0] s,
                                  logic [15:0] k, logic [15:0] aa, logic [15:0] ar);
        write_reg(REG_THRESHOLD, t);
        write_reg(REG_KNEE_WIDTH, w);
        write_reg(REG_RATIO_SLOPE, s);
        write_reg(REG_KNEE_SCALE, k);
        write_reg(REG_ATTACK_COEF, aa);
        write_reg(REG_RELEASE_COEF, ar);
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every expected word has come back, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (gain_sb.pending_gain.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [15:0] clamp_level(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return 16'(v);
    endfunction

    // Random level, weighted towards the knee and the threshold neighbourhood
    function automatic logic [15:0] pick_level();
        longint v;
        longint half_w;
        half_w = gain_sb.kw / 2;
        case ($urandom_range(0, 9))
            0, 1, 2:
                v = gain_sb.thr + longint'($urandom_range(0, 2 * half_w + 4)) - half_w - 2;
            3:
                v = gain_sb.thr + ($urandom_range(0, 1) ? 1 : -1)
                    * ((gain_sb.kw + longint'($urandom_range(0, 1))) >> 1);
            4, 5, 6:
                v = gain_sb.thr + longint'($urandom_range(0, 8192)) - 4096;
            default:
                v = longint'($signed(16'($urandom)));
        endcase
        return clamp_level(v);
    endfunction

    // Knee edges, threshold neighbours and the level extremes for the current setting
    task automatic send_edges();
        longint half_w;
        half_w = gain_sb.kw / 2;
        send_level(clamp_level(gain_sb.thr));
        send_level(clamp_level(gain_sb.thr - 1));
        send_level(clamp_level(gain_sb.thr + 1));
        send_level(clamp_level(gain_sb.thr - half_w - 1));
        send_level(clamp_level(gain_sb.thr - half_w));
        send_level(clamp_level(gain_sb.thr + half_w));
        send_level(clamp_level(gain_sb.thr + half_w + 1));
        send_level(16'h8000);
        send_level(16'h7FFF);
    endtask

    task automatic run_setting();
        send_edges();
        repeat (ITEMS_PER_SETTING) send_level(pick_level());
        wait_drained();
    endtask

    // Receiver: random stalls, steady stretches and two long hold-offs
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_steady = !take_steady;
            stall = take_steady ? 0 : $urandom_range(0, 11);
            if (words_seen == 150 || words_seen == 700)
                stall = LONG_HOLD_CYCLES;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            gain_sb.check_word(m_tdata);
            words_seen++;
            @(negedge clk);
        end
    end

    // Main sequence
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: extremes, zero, sign boundary, knee edges
        send_level(16'h8000);
        send_level(16'h7FFF);
        send_level(16'h0000);
        send_level(16'hFFFF);
        send_level(16'h5555);
        send_level(16'hAAAA);
        send_level(16'h0001);
        send_edges();
        wait_drained();
        repeat (ITEMS_PER_SETTING) send_level(pick_level());
        wait_drained();

        // hard knee, inconsistent knee scale, zero coefficients follow at once
        apply_settings(16'h0000, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000);
        run_setting();

        // widest knee, steepest slope, slowest detector
        apply_settings(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_setting();

        // top threshold, knee width written with the spare top bit, flat slope
        apply_settings(16'h7FFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
        run_setting();

        // positive slope expands instead of compressing
        apply_settings(16'hF600, 16'h0400, 16'h4000, 16'h2000, 16'hF000, 16'h0100);
        run_setting();

        // 8:1 ratio with a consistent knee scale
        apply_settings(16'hF600, 16'h0800, 16'h9000, 16'h1000, 16'hEA60, 16'hFDE8);
        run_setting();

        // random setting
        apply_settings(16'($urandom), 16'($urandom), 16'(-$urandom_range(0, 32768)),
                       16'($urandom), 16'($urandom), 16'($urandom));
        run_setting();

        if (gain_sb.fails == 0 && gain_sb.pending_gain.size() == 0)
            $display("soft_knee_compressor_gain_tb: PASS");
        else
            $display("soft_knee_compressor_gain_tb: FAIL");
        $finish;
    end

    // Hard limit on the run
    initial
    begin
        #(TIMEOUT_NS);
        $display("soft_knee_compressor_gain_tb: FAIL");
        $finish;
    end

endmodule
